// ===== sv/xsb_pkg.sv =====
// Shared types, codes and constant tables for the XOR swizzle bank conflict search.
// Used by xsb_ctrl, xsb_dp and xor_swizzle_bank_conflict_search_top; no dependencies.
package xsb_pkg;

  // Width of one simulated thread's byte address: row (< 64) times stride,
  // plus a swizzled column (< 2^14), fits 23 bits; times element size (5 bits).
  localparam int unsigned THR_BASE_W = 23;
  localparam int unsigned ADDR_W     = THR_BASE_W + 5;
  localparam int unsigned RECIP_W    = ADDR_W + 1;

  // Address operation: row * stride (32 bits) plus a 16 bit swizzled column.
  localparam int unsigned OP_BASE_W  = 33;
  localparam int unsigned OP_ADDR_W  = OP_BASE_W + 5;
  localparam int unsigned BYTE_ADDR_W = 40;

  // Remainder widths after the reciprocal estimate: below twice the divisor.
  localparam int unsigned REM_BW_W = 6;
  localparam int unsigned REM_NB_W = 7;

  localparam int unsigned CNT_W      = 6;
  localparam int unsigned SWZ_BITS_W = 4;
  localparam int unsigned MAX_DIVISOR = 64;

  // Reciprocal table: floor(2^ADDR_W / d); entry zero stands in for d = 1.
  localparam logic [RECIP_W-1:0] RECIP_ONE = {1'b1, {ADDR_W{1'b0}}};
  localparam logic [RECIP_W-1:0] RECIP_TBL [0:MAX_DIVISOR] = '{
    RECIP_ONE / 1,
    RECIP_ONE / 1,  RECIP_ONE / 2,  RECIP_ONE / 3,  RECIP_ONE / 4,
    RECIP_ONE / 5,  RECIP_ONE / 6,  RECIP_ONE / 7,  RECIP_ONE / 8,
    RECIP_ONE / 9,  RECIP_ONE / 10, RECIP_ONE / 11, RECIP_ONE / 12,
    RECIP_ONE / 13, RECIP_ONE / 14, RECIP_ONE / 15, RECIP_ONE / 16,
    RECIP_ONE / 17, RECIP_ONE / 18, RECIP_ONE / 19, RECIP_ONE / 20,
    RECIP_ONE / 21, RECIP_ONE / 22, RECIP_ONE / 23, RECIP_ONE / 24,
    RECIP_ONE / 25, RECIP_ONE / 26, RECIP_ONE / 27, RECIP_ONE / 28,
    RECIP_ONE / 29, RECIP_ONE / 30, RECIP_ONE / 31, RECIP_ONE / 32,
    RECIP_ONE / 33, RECIP_ONE / 34, RECIP_ONE / 35, RECIP_ONE / 36,
    RECIP_ONE / 37, RECIP_ONE / 38, RECIP_ONE / 39, RECIP_ONE / 40,
    RECIP_ONE / 41, RECIP_ONE / 42, RECIP_ONE / 43, RECIP_ONE / 44,
    RECIP_ONE / 45, RECIP_ONE / 46, RECIP_ONE / 47, RECIP_ONE / 48,
    RECIP_ONE / 49, RECIP_ONE / 50, RECIP_ONE / 51, RECIP_ONE / 52,
    RECIP_ONE / 53, RECIP_ONE / 54, RECIP_ONE / 55, RECIP_ONE / 56,
    RECIP_ONE / 57, RECIP_ONE / 58, RECIP_ONE / 59, RECIP_ONE / 60,
    RECIP_ONE / 61, RECIP_ONE / 62, RECIP_ONE / 63, RECIP_ONE / 64
  };

  typedef enum logic [1:0] {
    CFG_ELEMENT_BYTES = 2'd0,
    CFG_WARP_THREADS  = 2'd1,
    CFG_BANK_WIDTH    = 2'd2,
    CFG_BANK_TOTAL    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_ANALYZE = 1'b0,
    OP_ADDRESS = 1'b1
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_COUNT,
    ST_TRIAL,
    ST_ISSUE,
    ST_DRAIN,
    ST_EVAL,
    ST_ADDR_BASE,
    ST_ADDR_SCALE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        opcode;
    logic [16:0] tile_rows;
    logic [16:0] tile_cols;
    logic [15:0] elem_row;
    logic [15:0] elem_col;
    logic [15:0] row_stride;
  } in_req_t;

  typedef struct packed {
    logic [2:0]             chosen_bits;
    logic [CNT_W-1:0]       conflict_count;
    logic                   plain_conflicts;
    logic [BYTE_ADDR_W-1:0] byte_address;
  } out_rsp_t;

  typedef struct packed {
    logic [4:0] element_bytes;
    logic [6:0] warp_threads;
    logic [4:0] bank_width_bytes;
    logic [6:0] bank_total;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic count;
    logic trial_start;
    logic issue;
    logic eval;
    logic addr_base;
    logic addr_scale;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic issue_done;
    logic pipe_busy;
    logic search_done;
    logic addr_op;
  } sts_t;

  // Swizzled column: col ^ ((row & mask) << bits), bits up to 15.
  function automatic logic [15:0] swz_col(input logic [15:0] row, input logic [15:0] col,
                                          input logic [SWZ_BITS_W-1:0] bits);
    logic [15:0] mask;
    mask = 16'((17'd1 << bits) - 17'd1);
    return col ^ ((row & mask) << bits);
  endfunction

endpackage

// ===== sv/xsb_ctrl.sv =====
// Sequencer for the swizzle search: walks setup, trials, address and result hand-off.
// Depends on xsb_pkg; drives xsb_dp through cmd_t and reads sts_t back.
module xsb_ctrl import xsb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:       if (in_valid_i) state_d = ST_SETUP;
      ST_SETUP:      state_d = ST_COUNT;
      ST_COUNT:      state_d = ST_TRIAL;
      ST_TRIAL:      state_d = ST_ISSUE;
      ST_ISSUE:      if (sts_i.issue_done) state_d = ST_DRAIN;
      ST_DRAIN:      if (!sts_i.pipe_busy) state_d = ST_EVAL;
      ST_EVAL: begin
        if (!sts_i.search_done) begin
          state_d = ST_TRIAL;
        end else if (sts_i.addr_op) begin
          state_d = ST_ADDR_BASE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_ADDR_BASE:  state_d = ST_ADDR_SCALE;
      ST_ADDR_SCALE: state_d = ST_DONE;
      ST_DONE:       if (out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SETUP:      cmd_o.setup = 1'b1;
      ST_COUNT:      cmd_o.count = 1'b1;
      ST_TRIAL:      cmd_o.trial_start = 1'b1;
      ST_ISSUE:      cmd_o.issue = !sts_i.issue_done;
      ST_DRAIN:      cmd_o = '0;
      ST_EVAL:       cmd_o.eval = 1'b1;
      ST_ADDR_BASE:  cmd_o.addr_base = 1'b1;
      ST_ADDR_SCALE: cmd_o.addr_scale = 1'b1;
      ST_DONE:       cmd_o.finish = out_free;
      default:       cmd_o = '0;
    endcase
  end

  // Hold the result valid until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/xsb_dp.sv =====
// Datapath: thread walker, six-stage bank mapping pipeline, bank hit set,
// best-width tracking and the final address; depends on xsb_pkg.
module xsb_dp import xsb_pkg::*; #(
  parameter int unsigned MAX_THREADS      = 64,
  parameter int unsigned MAX_SWIZZLE_BITS = 4,
  parameter int unsigned MAX_BANKS        = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_req_t  in_req_i,
  input  cfg_t     cfg_i,
  input  cmd_t     cmd_i,
  output sts_t     sts_o,
  output out_rsp_t out_rsp_o
);

  localparam int unsigned TCW = $clog2(MAX_THREADS + 1);
  localparam int unsigned CRW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int unsigned SBW = $clog2(MAX_SWIZZLE_BITS + 1);
  localparam int unsigned BKW = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
  localparam int unsigned PIPE_DEPTH = 6;

  // Captured request and per-item setup
  in_req_t          req_q;
  logic [16:0]      rows, cols;
  logic [16:0]      cols_q;
  logic [33:0]      tile_q;
  logic [4:0]       bw_eff, bw_q;
  logic [6:0]       nb_eff, nb_q;
  logic [6:0]       warp_eff;
  logic [RECIP_W-1:0] m_bw_q, m_nb_q;
  logic [TCW-1:0]   n_q;

  // Trial control
  logic [SBW-1:0]   bits_q, bits_d;
  logic [TCW-1:0]   t_q, t_d;
  logic [CRW-1:0]   r_q, r_d, c_q, c_d;
  logic             col_wrap;

  // Pipeline
  logic [PIPE_DEPTH-1:0] v_q;
  logic [15:0]             swz_thr;
  logic [CRW+15:0]         rs_prod;
  logic [THR_BASE_W-1:0]   s1_base_q;
  logic [ADDR_W-1:0]       s2_addr_q;
  logic [2*ADDR_W:0]       prod_bw;
  logic [ADDR_W-1:0]       s3_addr_q, s3_q0_q;
  logic [ADDR_W+4:0]       back_bw;
  logic [ADDR_W-1:0]       diff_bw;
  logic [REM_BW_W-1:0]     rem_bw;
  logic [ADDR_W-1:0]       s4_q_q;
  logic [2*ADDR_W:0]       prod_nb;
  logic [ADDR_W-1:0]       s5_q_q, s5_q1_q;
  logic [ADDR_W+6:0]       back_nb;
  logic [ADDR_W-1:0]       diff_nb;
  logic [REM_NB_W-1:0]     rem_nb, bank_full;
  logic [BKW-1:0]          s6_bank_q;

  // Conflict tally
  logic [MAX_BANKS-1:0] hits_q;
  logic [CNT_W-1:0]     conf_q;

  // Search result
  logic [CNT_W-1:0] best_q, best_d;
  logic [SBW-1:0]   best_bits_q, best_bits_d;
  logic             plain_q, plain_d;

  // Address operation
  logic [31:0]           op_prod;
  logic [15:0]           swz_op;
  logic [OP_BASE_W-1:0]  abase_q;
  logic [OP_ADDR_W-1:0]  addr_q;
  out_rsp_t              out_q;

  // Effective configuration
  assign bw_eff   = (cfg_i.bank_width_bytes == 5'd0) ? 5'd1 : cfg_i.bank_width_bytes;
  assign nb_eff   = (cfg_i.bank_total == 7'd0) ? 7'd1 :
                    ((cfg_i.bank_total > 7'(MAX_BANKS)) ? 7'(MAX_BANKS) : cfg_i.bank_total);
  assign warp_eff = (cfg_i.warp_threads > 7'(MAX_THREADS)) ? 7'(MAX_THREADS)
                                                            : cfg_i.warp_threads;

  // Tile shape: the address operation covers (row+1) by (col+1)
  assign rows = (req_q.opcode == OP_ADDRESS) ? 17'(req_q.elem_row) + 17'd1 : req_q.tile_rows;
  assign cols = (req_q.opcode == OP_ADDRESS) ? 17'(req_q.elem_col) + 17'd1 : req_q.tile_cols;

  // Capture request and setup values
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_req_i;
    end
    if (cmd_i.setup) begin
      cols_q <= cols;
      tile_q <= rows * cols;
      bw_q   <= bw_eff;
      nb_q   <= nb_eff;
      m_bw_q <= RECIP_TBL[{2'b00, bw_eff}];
      m_nb_q <= RECIP_TBL[nb_eff];
    end
    if (cmd_i.count) begin
      n_q <= (tile_q < 34'(warp_eff)) ? TCW'(tile_q) : TCW'(warp_eff);
    end
  end

  // Thread walker: row-major over the tile, one thread per issue
  assign col_wrap = (17'(c_q) + 17'd1) == cols_q;

  always_comb begin
    t_d = t_q;
    r_d = r_q;
    c_d = c_q;
    if (cmd_i.trial_start) begin
      t_d = '0;
      r_d = '0;
      c_d = '0;
    end else if (cmd_i.issue) begin
      t_d = t_q + TCW'(1);
      if (col_wrap) begin
        c_d = '0;
        r_d = r_q + CRW'(1);
      end else begin
        c_d = c_q + CRW'(1);
      end
    end
  end

  // Advance swizzle width after each trial that does not end the search
  always_comb begin
    bits_d = bits_q;
    if (cmd_i.load) begin
      bits_d = '0;
    end else if (cmd_i.eval && !sts_o.search_done) begin
      bits_d = bits_q + SBW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q    <= '0;
      r_q    <= '0;
      c_q    <= '0;
      bits_q <= '0;
      v_q    <= '0;
    end else begin
      t_q    <= t_d;
      r_q    <= r_d;
      c_q    <= c_d;
      bits_q <= bits_d;
      v_q    <= {v_q[PIPE_DEPTH-2:0], cmd_i.issue};
    end
  end

  // Stage 1: row * stride plus swizzled column
  assign swz_thr = swz_col(16'(r_q), 16'(c_q), SWZ_BITS_W'(bits_q));
  assign rs_prod = r_q * req_q.row_stride;

  // Stage 3: fix the quotient estimate by one compare and subtract
  assign back_bw = s3_q0_q * bw_q;
  assign diff_bw = s3_addr_q - back_bw[ADDR_W-1:0];
  assign rem_bw  = diff_bw[REM_BW_W-1:0];

  // Stage 5: remainder modulo the bank count
  assign back_nb   = s5_q1_q * nb_q;
  assign diff_nb   = s5_q_q - back_nb[ADDR_W-1:0];
  assign rem_nb    = diff_nb[REM_NB_W-1:0];
  assign bank_full = (rem_nb >= nb_q) ? rem_nb - nb_q : rem_nb;

  assign prod_bw = s2_addr_q * m_bw_q;
  assign prod_nb = s4_q_q * m_nb_q;

  always_ff @(posedge clk_i) begin
    s1_base_q <= THR_BASE_W'(rs_prod) + THR_BASE_W'(swz_thr);
    s2_addr_q <= s1_base_q * cfg_i.element_bytes;
    s3_addr_q <= s2_addr_q;
    s3_q0_q   <= prod_bw[ADDR_W +: ADDR_W];
    s4_q_q    <= s3_q0_q + ADDR_W'(rem_bw >= REM_BW_W'(bw_q));
    s5_q_q    <= s4_q_q;
    s5_q1_q   <= prod_nb[ADDR_W +: ADDR_W];
    s6_bank_q <= bank_full[BKW-1:0];
  end

  // Stage 6: mark the bank, count a repeat hit as a conflict
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q <= '0;
      conf_q <= '0;
    end else if (cmd_i.trial_start) begin
      hits_q <= '0;
      conf_q <= '0;
    end else if (v_q[PIPE_DEPTH-1]) begin
      hits_q[s6_bank_q] <= 1'b1;
      if (hits_q[s6_bank_q]) begin
        conf_q <= conf_q + CNT_W'(1);
      end
    end
  end

  // Keep the first width with the fewest conflicts
  always_comb begin
    best_d      = best_q;
    best_bits_d = best_bits_q;
    plain_d     = plain_q;
    if (bits_q == '0) begin
      best_d      = conf_q;
      best_bits_d = '0;
      plain_d     = (conf_q != '0);
    end else if (conf_q < best_q) begin
      best_d      = conf_q;
      best_bits_d = bits_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= '0;
      best_bits_q <= '0;
      plain_q     <= 1'b0;
    end else if (cmd_i.eval) begin
      best_q      <= best_d;
      best_bits_q <= best_bits_d;
      plain_q     <= plain_d;
    end
  end

  // Swizzled byte address of the requested element; at most 38 bits, never saturates
  assign op_prod = req_q.elem_row * req_q.row_stride;
  assign swz_op  = swz_col(req_q.elem_row, req_q.elem_col, SWZ_BITS_W'(best_bits_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr_base) begin
      abase_q <= OP_BASE_W'(op_prod) + OP_BASE_W'(swz_op);
    end
    if (cmd_i.addr_scale) begin
      addr_q <= abase_q * cfg_i.element_bytes;
    end
    if (cmd_i.finish) begin
      out_q.chosen_bits     <= 3'(best_bits_q);
      out_q.conflict_count  <= best_q;
      out_q.plain_conflicts <= plain_q;
      out_q.byte_address    <= (req_q.opcode == OP_ADDRESS) ? BYTE_ADDR_W'(addr_q) : '0;
    end
  end

  assign sts_o.issue_done  = (t_q == n_q);
  assign sts_o.pipe_busy   = |v_q;
  assign sts_o.search_done = (bits_q == SBW'(MAX_SWIZZLE_BITS)) || (best_d == '0);
  assign sts_o.addr_op     = (req_q.opcode == OP_ADDRESS);

  assign out_rsp_o = out_q;

endmodule

// ===== sv/xor_swizzle_bank_conflict_search_top.sv =====
// Top level of the XOR swizzle bank conflict search: configuration registers,
// sequencer and datapath; depends on xsb_pkg, xsb_ctrl and xsb_dp.
//
// One request is handled at a time. After setup the block runs
// up to MAX_SWIZZLE_BITS+1 trials; each trial sends n = min(warp_threads, rows*cols)
// simulated threads through a six-stage bank mapping pipeline at one thread per
// cycle, then drains it. Trials stop early once a conflict-free width turns up;
// an address operation then adds a base step and a scale step. Bank numbers come
// from reciprocal multiplies with a one-step correction, so no divider sits in
// the loop. The result sits in an output register, so the next request can be
// taken while it waits. Configuration writes are always taken and should only
// arrive while idle.
module xor_swizzle_bank_conflict_search_top import xsb_pkg::*; #(
  parameter int unsigned MAX_SWIZZLE_BITS = 4,
  parameter int unsigned MAX_THREADS      = 64,
  parameter int unsigned MAX_BANKS        = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_rsp_t out_rsp_o,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  cfg_idx_e cfg_index_i,
  input  logic [6:0] cfg_data_i
);

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.element_bytes    <= 5'd2;
      cfg_q.warp_threads     <= 7'd32;
      cfg_q.bank_width_bytes <= 5'd4;
      cfg_q.bank_total       <= 7'd32;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ELEMENT_BYTES: cfg_q.element_bytes    <= cfg_data_i[4:0];
        CFG_WARP_THREADS:  cfg_q.warp_threads     <= cfg_data_i;
        CFG_BANK_WIDTH:    cfg_q.bank_width_bytes <= cfg_data_i[4:0];
        CFG_BANK_TOTAL:    cfg_q.bank_total       <= cfg_data_i;
        default:           cfg_q                  <= cfg_q;
      endcase
    end
  end

  xsb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  xsb_dp #(
    .MAX_THREADS      (MAX_THREADS),
    .MAX_SWIZZLE_BITS (MAX_SWIZZLE_BITS),
    .MAX_BANKS        (MAX_BANKS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cfg_i     (cfg_q),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_rsp_o (out_rsp_o)
  );

  // One request in flight: a taken request drops ready on the next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // A conflict-free plain layout ends the search at width zero
  a_plain_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.plain_conflicts |->
      (out_rsp_o.chosen_bits == 3'd0) && (out_rsp_o.conflict_count == '0))
    else $error("width chosen although the plain layout is conflict free");

  // The best count never exceeds the plain count, so leftover conflicts imply plain ones
  a_best_le_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.conflict_count != '0) |-> out_rsp_o.plain_conflicts)
    else $error("conflicts remain but plain layout reported clean");

endmodule
